// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the sensor status table.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define SST_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while the active-low reset is asserted.
`define SST_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sst_pkg.sv =====
`timescale 1ns / 1ps
// Package of the sensor status table: sizes, codes and transaction types.
// Depends on nothing; imported by sensor_status_table.
package sst_pkg;

  localparam int unsigned SLOTS  = 8;
  localparam int unsigned WHEELS = 4;
  localparam int unsigned SLOT_W = $clog2(SLOTS);

  localparam int unsigned NUM_WHEEL_REGS = 4;
  localparam int unsigned WHEEL_W        = $clog2(NUM_WHEEL_REGS);
  localparam int unsigned CFG_IDX_W      = 3;

  localparam logic [1:0] ACT_INIT  = 2'd0;
  localparam logic [1:0] ACT_STORE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_ID   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_PRES  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV_BATT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNDERFLOW = 3'd7;

  localparam logic [7:0]  COUNT_WRAP   = 8'd254;
  localparam logic [4:0]  PRES_SCALE   = 5'd25;
  localparam logic [15:0] INVALID_CODE = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] sensor_id;
    logic [7:0]  pressure;
    logic [7:0]  pressure_state;
    logic [7:0]  battery;
  } sst_in_t;

  typedef struct packed {
    logic [31:0] slot_sensor_id;
    logic [15:0] pressure_code;
    logic [15:0] battery_code;
    logic [7:0]  receive_count;
    logic        last;
  } sst_out_t;

endpackage

// ===== rtl/sensor_status_table.sv =====
`timescale 1ns / 1ps
// Sensor status table: slot records keyed by sensor id, walked one slot per cycle.
// Depends on sst_pkg and assert_macros.svh.
//
//   channel   handshake            payload
//   command   start_i / busy_o     in_i (sst_in_t)
//   result    result_valid_o       result_o (sst_out_t)
//   config    cfg_valid_i/ready_o  cfg_index_i, cfg_data_i
//
// A slot counter steps through the table, one slot per cycle.
// Init and readout visit all slots; store stops at a matching or free slot, else the last one.
// Readout results appear in the cycle after their slot is visited, one per cycle.
// Reset clears the table and loads the register reset values; the receiver cannot stall.
`include "assert_macros.svh"

module sensor_status_table import sst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  sst_in_t              in_i,
  output logic                 result_valid_o,
  output sst_out_t             result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  logic              state_q, state_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  sst_in_t           item_q;

  logic [31:0] wheel_q [NUM_WHEEL_REGS];
  logic [31:0] free_id_q;
  logic [7:0]  inv_pres_q, inv_batt_q, underflow_q;

  logic [31:0] slot_id_q   [SLOTS];
  logic [7:0]  slot_pres_q [SLOTS];
  logic [7:0]  slot_batt_q [SLOTS];
  logic [7:0]  slot_cnt_q  [SLOTS];

  logic        result_valid_q;
  sst_out_t    result_q, result_d;

  logic        accept;
  logic [31:0] cur_id;
  logic [7:0]  cur_pres, cur_batt, cur_cnt;
  logic        hit_match, hit_free, at_last;
  logic [7:0]  new_pres;
  logic [7:0]  next_cnt;
  logic [15:0] pres_scaled;
  logic [31:0] init_id;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign cur_id    = slot_id_q[idx_q];
  assign cur_pres  = slot_pres_q[idx_q];
  assign cur_batt  = slot_batt_q[idx_q];
  assign cur_cnt   = slot_cnt_q[idx_q];
  assign hit_match = (cur_id == item_q.sensor_id);
  assign hit_free  = (cur_id == free_id_q);
  assign at_last   = (idx_q == LAST_SLOT);

  assign new_pres    = (item_q.pressure_state == underflow_q) ? inv_pres_q : item_q.pressure;
  assign next_cnt    = (cur_cnt < COUNT_WRAP) ? cur_cnt + 8'd1 : 8'd1;
  assign pres_scaled = 16'(cur_pres) * 16'(PRES_SCALE);
  assign init_id     = ({{(32 - SLOT_W){1'b0}}, idx_q} < 32'(WHEELS))
                       ? wheel_q[idx_q[WHEEL_W-1:0]] : free_id_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    if (state_q == ST_IDLE) begin
      if (accept) begin
        state_d = ST_RUN;
        idx_d   = '0;
      end
    end else begin
      idx_d = idx_q + SLOT_W'(1);
      unique case (item_q.action) inside
        ACT_STORE: begin
          if (hit_match || hit_free || at_last) begin
            state_d = ST_IDLE;
          end
        end
        ACT_INIT, ACT_READ: begin
          if (at_last) begin
            state_d = ST_IDLE;
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    result_d.slot_sensor_id = cur_id;
    result_d.pressure_code  = (cur_pres == inv_pres_q) ? INVALID_CODE : pres_scaled;
    result_d.battery_code   = (cur_batt == inv_batt_q) ? INVALID_CODE : {8'd0, cur_batt};
    result_d.receive_count  = cur_cnt;
    result_d.last           = at_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      idx_q          <= '0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      idx_q          <= idx_d;
      result_valid_q <= (state_q == ST_RUN) && (item_q.action == ACT_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_i;
    end
    result_q <= result_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WHEEL_REGS; i++) begin
        wheel_q[i] <= '0;
      end
      free_id_q   <= 32'hFFFF_FFFF;
      inv_pres_q  <= 8'hFF;
      inv_batt_q  <= 8'hFF;
      underflow_q <= 8'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i) inside
        REG_WHEEL_0, REG_WHEEL_1, REG_WHEEL_2, REG_WHEEL_3: begin
          wheel_q[cfg_index_i[WHEEL_W-1:0]] <= cfg_data_i;
        end
        REG_FREE_ID:   free_id_q   <= cfg_data_i;
        REG_INV_PRES:  inv_pres_q  <= cfg_data_i[7:0];
        REG_INV_BATT:  inv_batt_q  <= cfg_data_i[7:0];
        REG_UNDERFLOW: underflow_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_id_q[i]   <= '0;
        slot_pres_q[i] <= '0;
        slot_batt_q[i] <= '0;
        slot_cnt_q[i]  <= '0;
      end
    end else if (state_q == ST_RUN) begin
      case (item_q.action)
        ACT_INIT: begin
          slot_id_q[idx_q]   <= init_id;
          slot_pres_q[idx_q] <= '0;
          slot_batt_q[idx_q] <= '0;
          slot_cnt_q[idx_q]  <= '0;
        end
        ACT_STORE: begin
          if (hit_match || hit_free) begin
            slot_id_q[idx_q]   <= item_q.sensor_id;
            slot_pres_q[idx_q] <= new_pres;
            slot_batt_q[idx_q] <= item_q.battery;
            slot_cnt_q[idx_q]  <= hit_match ? next_cnt : 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  `SST_ASSERT_NXT(a_busy_after_start, clk_i, rst_ni, accept, busy_o, "busy not raised after start")
  `SST_ASSERT_IMP(a_result_in_readout, clk_i, rst_ni, result_valid_q, item_q.action == ACT_READ,
                  "result strobe outside a readout")
  `SST_ASSERT_IMP(a_last_ends_readout, clk_i, rst_ni, result_valid_o && result_o.last, !busy_o,
                  "sequencer still busy at the final result")
  `SST_ASSERT_NXT(a_results_back_to_back, clk_i, rst_ni,
                  result_valid_o && !result_o.last, result_valid_o,
                  "gap inside a readout")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of sensor_status_table: directed and random command transactions,
// with a predictor of the slot table in the testbench. Depends on sst_pkg and the RTL.
module tb;
  import sst_pkg::*;

  localparam logic [1:0] ACT_UNUSED     = 2'd3;
  localparam int unsigned CFG_REGS       = 1 << CFG_IDX_W;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 start_i     = 1'b0;
  logic                 busy_o;
  sst_in_t              in_i        = '0;
  logic                 result_valid_o;
  sst_out_t             result_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]          cfg_data_i  = '0;

  sensor_status_table DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  sst_in_t     cmd_q[$];
  sst_out_t    readout_q[$];
  logic [31:0] cfg_mirror[CFG_REGS];
  logic [31:0] cfg_plan[CFG_REGS];
  logic [31:0] tbl_id[SLOTS];
  logic [7:0]  tbl_pres[SLOTS];
  logic [7:0]  tbl_batt[SLOTS];
  logic [7:0]  tbl_count[SLOTS];
  logic [31:0] id_pool[6];
  int unsigned idle_pct = 26;
  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_init = 0, n_store = 0, n_read = 0, n_unused = 0;
  int unsigned n_results = 0, n_cfg = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report(input string msg);
    err_count++;
    if (err_count <= 100) $display("MISMATCH: %s", msg);
  endtask

  task automatic check_field(input string what, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report($sformatf("result %0d: %s is %h, expected %h", n_results, what, got, want));
  endtask

  function automatic logic [7:0] stored_pressure(input sst_in_t c);
    if (c.pressure_state == cfg_mirror[REG_UNDERFLOW][7:0]) return cfg_mirror[REG_INV_PRES][7:0];
    return c.pressure;
  endfunction

  task automatic predict_command(input sst_in_t c);
    bit       done;
    sst_out_t r;
    done = 1'b0;
    case (c.action)
      ACT_INIT: begin
        n_init++;
        for (int unsigned i = 0; i < SLOTS; i++) begin
          tbl_pres[i]  = '0;
          tbl_batt[i]  = '0;
          tbl_count[i] = '0;
          tbl_id[i] = (i < WHEELS && i < NUM_WHEEL_REGS) ? cfg_mirror[i] : cfg_mirror[REG_FREE_ID];
        end
      end
      ACT_STORE: begin
        n_store++;
        for (int unsigned i = 0; i < SLOTS; i++) begin
          if (!done && tbl_id[i] == c.sensor_id) begin
            tbl_pres[i]  = stored_pressure(c);
            tbl_batt[i]  = c.battery;
            tbl_count[i] = (tbl_count[i] < COUNT_WRAP) ? tbl_count[i] + 8'd1 : 8'd1;
            done = 1'b1;
          end else if (!done && tbl_id[i] == cfg_mirror[REG_FREE_ID]) begin
            tbl_id[i]    = c.sensor_id;
            tbl_pres[i]  = stored_pressure(c);
            tbl_batt[i]  = c.battery;
            tbl_count[i] = 8'd1;
            done = 1'b1;
          end
        end
      end
      ACT_READ: begin
        n_read++;
        for (int unsigned i = 0; i < SLOTS; i++) begin
          r.slot_sensor_id = tbl_id[i];
          r.pressure_code  = (tbl_pres[i] == cfg_mirror[REG_INV_PRES][7:0]) ? INVALID_CODE
                             : 16'(tbl_pres[i]) * 16'(PRES_SCALE);
          r.battery_code   = (tbl_batt[i] == cfg_mirror[REG_INV_BATT][7:0]) ? INVALID_CODE
                             : 16'(tbl_batt[i]);
          r.receive_count  = tbl_count[i];
          r.last           = (i == SLOTS - 1);
          readout_q.push_back(r);
        end
      end
      default: n_unused++;
    endcase
  endtask

  // Driver: a command is accepted at an edge with start_i high and busy_o low.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) predict_command(in_i);
      if (!(start_i && busy_o)) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_i    <= cmd_q.pop_front();
          start_i <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    sst_out_t want;
    if (rst_ni && result_valid_o) begin
      n_results++;
      if (readout_q.size() == 0) begin
        report($sformatf("result %0d arrived with none expected", n_results));
      end else begin
        want = readout_q.pop_front();
        check_field("slot_sensor_id", result_o.slot_sensor_id, want.slot_sensor_id);
        check_field("pressure_code", result_o.pressure_code, want.pressure_code);
        check_field("battery_code", result_o.battery_code, want.battery_code);
        check_field("receive_count", result_o.receive_count, want.receive_count);
        check_field("last", result_o.last, want.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d commands queued and %0d results outstanding.",
                 cmd_q.size(), readout_q.size());
        $display("tb failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_mirror[idx] = (idx < REG_INV_PRES) ? data : {24'd0, data[7:0]};
    n_cfg++;
  endtask

  task automatic write_plan();
    for (int unsigned i = 0; i < CFG_REGS; i++) cfg_write(CFG_IDX_W'(i), cfg_plan[i]);
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (cmd_q.size() != 0 || start_i || readout_q.size() != 0) @(negedge clk_i);
    repeat (SLOTS + 4) @(posedge clk_i);
  endtask

  task automatic begin_phase(input int unsigned pct);
    @(negedge clk_i);
    idle_pct = pct;
  endtask

  task automatic push_cmd(input logic [1:0] act, input logic [31:0] id, input logic [7:0] pres,
                          input logic [7:0] pstate, input logic [7:0] batt);
    sst_in_t c;
    c.action         = act;
    c.sensor_id      = id;
    c.pressure       = pres;
    c.pressure_state = pstate;
    c.battery        = batt;
    cmd_q.push_back(c);
  endtask

  function automatic logic [31:0] pick_id();
    int unsigned k;
    k = $urandom_range(9);
    if (k < NUM_WHEEL_REGS) return cfg_mirror[k];
    if (k == 4) return cfg_mirror[REG_FREE_ID];
    if (k == 5) return $urandom();
    return id_pool[$urandom_range(5)];
  endfunction

  // Mostly stores against a small id pool so slots match, fill up and overflow.
  task automatic push_random(input int unsigned count);
    int unsigned r;
    logic [1:0]  act;
    logic [7:0]  pres, pstate, batt;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 5) act = ACT_INIT;
      else if (r < 20) act = ACT_READ;
      else if (r < 23) act = ACT_UNUSED;
      else act = ACT_STORE;
      pres   = ($urandom_range(9) == 0) ? cfg_mirror[REG_INV_PRES][7:0] : 8'($urandom());
      pstate = ($urandom_range(2) == 0) ? cfg_mirror[REG_UNDERFLOW][7:0] : 8'($urandom());
      batt   = ($urandom_range(9) == 0) ? cfg_mirror[REG_INV_BATT][7:0] : 8'($urandom());
      push_cmd(act, (act == ACT_STORE) ? pick_id() : $urandom(), pres, pstate, batt);
    end
  endtask

  initial begin
    for (int unsigned i = 0; i < CFG_REGS; i++) cfg_mirror[i] = '0;
    cfg_mirror[REG_FREE_ID]   = 32'hFFFF_FFFF;
    cfg_mirror[REG_INV_PRES]  = 32'h0000_00FF;
    cfg_mirror[REG_INV_BATT]  = 32'h0000_00FF;
    cfg_mirror[REG_UNDERFLOW] = 32'h0000_0001;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      tbl_id[i]    = '0;
      tbl_pres[i]  = '0;
      tbl_batt[i]  = '0;
      tbl_count[i] = '0;
    end
    for (int unsigned i = 0; i < 6; i++) id_pool[i] = $urandom();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Register reset values; the table is read before the first init.
    begin_phase(26);
    push_cmd(ACT_READ,   32'h0,         8'h00, 8'h00, 8'h00);
    push_cmd(ACT_STORE,  32'h0,         8'hFF, 8'h00, 8'h00);
    push_cmd(ACT_UNUSED, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
    push_cmd(ACT_READ,   32'h0,         8'h00, 8'h00, 8'h00);
    push_cmd(ACT_INIT,   32'h0,         8'h00, 8'h00, 8'h00);
    push_cmd(ACT_READ,   32'h0,         8'h00, 8'h00, 8'h00);
    push_cmd(ACT_STORE,  32'hFFFF_FFFF, 8'h00, 8'h00, 8'h80);
    push_cmd(ACT_STORE,  32'h1234_5678, 8'h40, 8'h01, 8'h7F);
    push_cmd(ACT_STORE,  32'h1234_5678, 8'hAB, 8'h00, 8'hFF);
    push_cmd(ACT_STORE,  32'h0,         8'h00, 8'hFF, 8'h00);
    push_cmd(ACT_STORE,  32'hA5A5_A5A5, 8'h01, 8'hFE, 8'h01);
    push_cmd(ACT_STORE,  32'h5A5A_5A5A, 8'h55, 8'hAA, 8'hAA);
    push_cmd(ACT_STORE,  32'h0000_0001, 8'hAA, 8'h55, 8'h55);
    push_cmd(ACT_STORE,  32'hDEAD_BEEF, 8'h11, 8'h22, 8'h33);
    push_cmd(ACT_READ,   32'h0,         8'h00, 8'h00, 8'h00);
    push_cmd(ACT_STORE,  32'h0000_0001, 8'hFF, 8'hFE, 8'hFE);
    push_cmd(ACT_READ,   32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
    push_cmd(ACT_INIT,   32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
    push_cmd(ACT_READ,   32'h0,         8'h00, 8'h00, 8'h00);
    drain();

    // Low free and invalid markers; a free marker that equals a wheel id.
    cfg_plan[REG_WHEEL_0]   = 32'h0;
    cfg_plan[REG_WHEEL_1]   = 32'hFFFF_FFFF;
    cfg_plan[REG_WHEEL_2]   = $urandom();
    cfg_plan[REG_WHEEL_3]   = $urandom();
    cfg_plan[REG_FREE_ID]   = 32'h0;
    cfg_plan[REG_INV_PRES]  = {24'($urandom_range(255)), 8'h00};
    cfg_plan[REG_INV_BATT]  = 32'hFFFF_FF00;
    cfg_plan[REG_UNDERFLOW] = 32'h0000_00FF;
    write_plan();
    begin_phase(26);
    push_cmd(ACT_READ, 32'h0, 8'h00, 8'h00, 8'h00);
    push_cmd(ACT_INIT, 32'h0, 8'h00, 8'h00, 8'h00);
    push_random(28);
    drain();

    for (int unsigned i = 0; i < CFG_REGS; i++) cfg_plan[i] = $urandom();
    write_plan();
    begin_phase(85);
    push_cmd(ACT_READ, 32'h0, 8'h00, 8'h00, 8'h00);
    push_cmd(ACT_INIT, 32'h0, 8'h00, 8'h00, 8'h00);
    push_random(28);
    drain();

    // High free and invalid markers; a run of stores on one id counts up its receive count.
    for (int unsigned i = 0; i < NUM_WHEEL_REGS; i++) cfg_plan[i] = $urandom();
    cfg_plan[REG_FREE_ID]   = 32'hFFFF_FFFF;
    cfg_plan[REG_INV_PRES]  = 32'h0000_00FF;
    cfg_plan[REG_INV_BATT]  = 32'h0000_00FF;
    cfg_plan[REG_UNDERFLOW] = 32'hFFFF_FF00;
    write_plan();
    begin_phase(0);
    push_cmd(ACT_READ, 32'h0, 8'h00, 8'h00, 8'h00);
    push_cmd(ACT_INIT, 32'h0, 8'h00, 8'h00, 8'h00);
    push_random(26);
    push_cmd(ACT_INIT, 32'h0, 8'h00, 8'h00, 8'h00);
    for (int unsigned n = 0; n < 10; n++)
      push_cmd(ACT_STORE, cfg_plan[REG_WHEEL_0], 8'($urandom()), 8'($urandom()), 8'($urandom()));
    push_cmd(ACT_READ, 32'h0, 8'h00, 8'h00, 8'h00);
    drain();

    $display("Ran %0d init, %0d store, %0d readout and %0d unused commands under four settings,",
             n_init, n_store, n_read, n_unused);
    $display("checking %0d readout results after %0d register writes.", n_results, n_cfg);
    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sst_pkg.sv
rtl/sensor_status_table.sv
test/tb.sv
